// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files that carry checks.
// Every check samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every enabled clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== rtl/rqr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_pkg: shared types and constants of the ring queue
// Sizes, request and error codes, and the control/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package rqr_pkg;

	localparam int DEPTH       = 16;
	localparam int HANDLE_BITS = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int KIND_W    = 2;
	localparam int HANDLE_FW = 32;
	localparam int COUNT_FW  = 5;
	localparam int ERR_W     = 2;
	localparam int SIZE_FW   = 5;

	localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'((DEPTH < 16) ? DEPTH : 16);

	typedef enum logic [KIND_W-1:0] {
		REQ_ADD  = 2'd0,
		REQ_GET  = 2'd1,
		REQ_ROLL = 2'd2
	} req_kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_code_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} ctrl_state_t;

	typedef struct packed {
		logic exec;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/rqr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module rqr_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rqr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_ctrl: request sequencer of the ring queue
// Takes one request at a time, lets the datapath execute it, then waits until
// the output register is free to load the result.
// ----------------------------------------------------------------------------
module rqr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rqr_pkg::dp_status_t status,
	output rqr_pkg::ctrl_cmd_t       cmd
);
	import rqr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = in_valid;
			end
			ST_LOAD: begin
				cmd.load = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rqr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_dp: ring queue datapath
// Head and tail indices, fill count, size register, the handle store and the
// output register.
// ----------------------------------------------------------------------------
module rqr_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rqr_pkg::ctrl_cmd_t             cmd,
	output rqr_pkg::dp_status_t                 status,
	input  wire logic [rqr_pkg::KIND_W-1:0]     kind,
	input  wire logic [rqr_pkg::HANDLE_FW-1:0]  entry_handle,
	input  wire logic                           cfg_we,
	input  wire logic [rqr_pkg::SIZE_FW-1:0]    cfg_wdata,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic      [rqr_pkg::HANDLE_FW-1:0]  read_handle,
	output logic      [rqr_pkg::COUNT_FW-1:0]   fill_count,
	output logic      [rqr_pkg::ERR_W-1:0]      error_code
);
	import rqr_pkg::*;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] size_q;
	err_code_t        err_q;
	logic             rd_ok_q;

	logic [IDX_W-1:0] head_d;
	logic [IDX_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;
	err_code_t        err_d;
	logic             rd_ok_d;

	logic [IDX_W:0]   head_inc;
	logic [IDX_W:0]   tail_inc;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;
	logic [IDX_W-1:0] head_prev;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] size_new;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic                   ram_re;
	logic [HANDLE_BITS-1:0] ram_wdata;
	logic [HANDLE_BITS-1:0] ram_rdata;

	// Both indices wrap at the configured size, not at the store depth.
	assign head_inc  = {1'b0, head_q} + 1'b1;
	assign tail_inc  = {1'b0, tail_q} + 1'b1;
	assign head_next = (head_inc >= size_q) ? '0 : IDX_W'(head_inc);
	assign tail_next = (tail_inc >= size_q) ? '0 : IDX_W'(tail_inc);
	assign head_prev = (head_q == '0 || head_q >= size_q) ? IDX_W'(size_q - 1'b1)
	                                                     : IDX_W'(head_q - 1'b1);
	assign full  = (count_q >= size_q);
	assign empty = (count_q == '0);

	assign ram_wdata = HANDLE_BITS'(64'(entry_handle));

	always_comb begin
		if (cfg_wdata == '0) begin
			size_new = CNT_W'(1);
		end else if (32'(cfg_wdata) > DEPTH) begin
			size_new = CNT_W'(DEPTH);
		end else begin
			size_new = CNT_W'(cfg_wdata);
		end
	end

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		err_d     = ERR_OK;
		rd_ok_d   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_re    = 1'b0;
		case (kind)
			REQ_ADD: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					ram_we  = cmd.exec;
					tail_d  = tail_next;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			REQ_GET: begin
				if (empty) begin
					err_d = ERR_EMPTY;
				end else begin
					ram_re  = cmd.exec;
					rd_ok_d = 1'b1;
					head_d  = head_next;
					count_d = CNT_W'(count_q - 1'b1);
				end
			end
			REQ_ROLL: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					ram_we    = cmd.exec;
					ram_waddr = head_prev;
					head_d    = head_prev;
					count_d   = CNT_W'(count_q + 1'b1);
				end
			end
			default: begin
				err_d = ERR_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			size_q  <= SIZE_RESET;
		end else if (cfg_we) begin
			// A new size empties the queue; the store keeps its contents.
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			size_q  <= size_new;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			err_q   <= err_d;
			rd_ok_q <= rd_ok_d;
		end
	end

	rqr_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	assign status.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_handle <= rd_ok_q ? HANDLE_FW'(64'(ram_rdata)) : '0;
			fill_count  <= COUNT_FW'(count_q);
			error_code  <= err_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ring_queue_with_rollback.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ring_queue_with_rollback: circular handle queue with push to the front
// Requests arrive on the in_* channel (kind, entry_handle) and each one gives
// exactly one result on the out_* channel (read_handle, fill_count, error_code).
// A request transaction is taken when in_valid and in_ready are high; its
// result is loaded into the output register once the output register is free.
// No new request is taken until the last one's result is loaded: the handle
// store has a registered read, and the result is loaded after the store read.
// If the receiver stalls, the result waits in the output register and the next
// request is still taken; that request then waits until the output register
// is free before its own result is loaded.
// cfg_we/cfg_wdata write the ring size in use (zero means one, above the store
// depth means the depth) and empty the queue; write it only while idle.
// After reset the queue is empty, the size is 16 and out_valid is low. Store
// entries are undefined until written and have no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_queue_with_rollback (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rqr_pkg::KIND_W-1:0]     kind,
	input  wire logic [rqr_pkg::HANDLE_FW-1:0]  entry_handle,
	input  wire logic                           cfg_we,
	input  wire logic [rqr_pkg::SIZE_FW-1:0]    cfg_wdata,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [rqr_pkg::HANDLE_FW-1:0]  read_handle,
	output logic      [rqr_pkg::COUNT_FW-1:0]   fill_count,
	output logic      [rqr_pkg::ERR_W-1:0]      error_code
);
	import rqr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rqr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.kind         (kind),
		.entry_handle (entry_handle),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.read_handle  (read_handle),
		.fill_count   (fill_count),
		.error_code   (error_code)
	);

	// Requests are handled one at a time.
	`ASSERT_CLK(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "request taken while busy")
	`ASSERT_NEVER(a_count_range, out_valid && (32'(fill_count) > DEPTH), "fill count above depth")
	`ASSERT_CLK(a_empty_result, (out_valid && error_code == ERR_EMPTY) |-> (fill_count == '0 && read_handle == '0), "empty error with data")
	`ASSERT_CLK(a_full_result, (out_valid && error_code == ERR_FULL) |-> (read_handle == '0 && fill_count != '0), "full error with data")

endmodule
`default_nettype wire

// ===== tb/ring_queue_with_rollback_test.sv =====
// ----------------------------------------------------------------------------
// ring_queue_with_rollback_test: self-checking bench for the ring queue
// A planned list of requests and ring resizes feeds a clocked driver. A mirror
// of the ring predicts each reply as its request is taken, and a clocked
// monitor compares every reply field against the oldest prediction. Both
// channels stall at random, with one long receiver hold-off and several
// sender pauses that let the queue drain.
// ----------------------------------------------------------------------------
module ring_queue_with_rollback_test;
	import rqr_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1900;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_AFTER = 400;
	localparam int CYCLE_LIMIT = 1000000;

	typedef enum {
		OP_REQUEST,
		OP_RESIZE,
		OP_PAUSE
	} plan_op_t;

	typedef struct {
		plan_op_t op;
		logic [KIND_W-1:0] kind;
		logic [HANDLE_FW-1:0] handle;
		logic [SIZE_FW-1:0] size;
		int gap;
	} plan_item_t;

	typedef struct packed {
		logic [HANDLE_FW-1:0] handle;
		logic [COUNT_FW-1:0] count;
		err_code_t err;
	} ring_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = '0;
	logic [HANDLE_FW-1:0] entry_handle = '0;
	logic cfg_we = 1'b0;
	logic [SIZE_FW-1:0] cfg_wdata = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [HANDLE_FW-1:0] read_handle;
	logic [COUNT_FW-1:0] fill_count;
	logic [ERR_W-1:0] error_code;

	ring_queue_with_rollback DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.entry_handle(entry_handle),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_handle(read_handle),
		.fill_count(fill_count),
		.error_code(error_code)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the ring, updated in the order requests are taken.
	logic [HANDLE_FW-1:0] ring_store [DEPTH];
	int ring_size = DEPTH;
	int ring_head = 0;
	int ring_tail = 0;
	int ring_held = 0;

	plan_item_t request_plan [$];
	ring_reply_t ring_replies_due [$];
	int requests_issued = 0;
	int results_seen = 0;
	int fault_count = 0;
	int cycle_count = 0;

	function automatic void ring_resize(input logic [SIZE_FW-1:0] v);
		if (v == 0) begin
			ring_size = 1;
		end else if (v > DEPTH) begin
			ring_size = DEPTH;
		end else begin
			ring_size = v;
		end
		ring_head = 0;
		ring_tail = 0;
		ring_held = 0;
	endfunction

	function automatic ring_reply_t ring_apply(input logic [KIND_W-1:0] k,
		input logic [HANDLE_FW-1:0] h);
		ring_reply_t r;
		r.handle = '0;
		r.err = ERR_OK;
		case (k)
			REQ_ADD: begin
				if (ring_held >= ring_size) begin
					r.err = ERR_FULL;
				end else begin
					ring_store[ring_tail] = h;
					ring_tail = (ring_tail + 1 >= ring_size) ? 0 : ring_tail + 1;
					ring_held++;
				end
			end
			REQ_GET: begin
				if (ring_held == 0) begin
					r.err = ERR_EMPTY;
				end else begin
					r.handle = ring_store[ring_head];
					ring_head = (ring_head + 1 >= ring_size) ? 0 : ring_head + 1;
					ring_held--;
				end
			end
			REQ_ROLL: begin
				if (ring_held >= ring_size) begin
					r.err = ERR_FULL;
				end else begin
					ring_head = (ring_head == 0 || ring_head >= ring_size) ?
						ring_size - 1 : ring_head - 1;
					ring_store[ring_head] = h;
					ring_held++;
				end
			end
			default: ;
		endcase
		r.count = COUNT_FW'(ring_held);
		return r;
	endfunction

	function automatic void plan_request(input logic [KIND_W-1:0] k,
		input logic [HANDLE_FW-1:0] h, input int g);
		plan_item_t it;
		it.op = OP_REQUEST;
		it.kind = k;
		it.handle = h;
		it.size = '0;
		it.gap = g;
		request_plan.push_back(it);
	endfunction

	function automatic void plan_resize(input logic [SIZE_FW-1:0] v);
		plan_item_t it;
		it.op = OP_RESIZE;
		it.kind = '0;
		it.handle = '0;
		it.size = v;
		it.gap = 0;
		request_plan.push_back(it);
	endfunction

	function automatic void plan_pause();
		plan_item_t it;
		it.op = OP_PAUSE;
		it.kind = '0;
		it.handle = '0;
		it.size = '0;
		it.gap = 0;
		request_plan.push_back(it);
	endfunction

	// Driver. The transaction counters are updated with nonblocking assignments
	// so that the driver and the monitor always see the same settled values.
	logic next_valid;
	logic next_cfg;
	int gap_left = 0;
	int idle_run = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			entry_handle <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			gap_left <= 0;
			idle_run <= 0;
		end else begin
			next_valid = in_valid;
			next_cfg = 1'b0;
			if (in_valid && in_ready) begin
				ring_replies_due.push_back(ring_apply(kind, entry_handle));
				requests_issued <= requests_issued + 1;
				next_valid = 1'b0;
			end
			if (!next_valid && !cfg_we) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (request_plan.size() != 0) begin
					if (request_plan[0].op == OP_REQUEST) begin
						if (request_plan[0].gap != 0) begin
							gap_left <= request_plan[0].gap - 1;
							request_plan[0].gap = 0;
						end else begin
							next_valid = 1'b1;
							kind <= request_plan[0].kind;
							entry_handle <= request_plan[0].handle;
							void'(request_plan.pop_front());
						end
					end else if (idle_run >= SETTLE_CYCLES) begin
						// Resizes and pauses proceed only once every reply is in.
						if (request_plan[0].op == OP_RESIZE) begin
							next_cfg = 1'b1;
							cfg_wdata <= request_plan[0].size;
							ring_resize(request_plan[0].size);
						end
						void'(request_plan.pop_front());
					end
				end
			end
			if (requests_issued == results_seen && !in_valid && !cfg_we) begin
				idle_run <= idle_run + 1;
			end else begin
				idle_run <= 0;
			end
			in_valid <= next_valid;
			cfg_we <= next_cfg;
		end
	end

	// Receiver readiness, including one long hold-off while requests keep coming.
	int hold_left = 0;
	int calm_left = 0;
	bit long_hold_done = 1'b0;
	int unsigned ready_roll;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			calm_left <= 0;
			long_hold_done <= 1'b0;
		end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER && in_valid &&
			out_valid) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (calm_left != 0) begin
			out_ready <= 1'b1;
			calm_left <= calm_left - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 3) begin
				out_ready <= 1'b1;
				calm_left <= $urandom_range(30, 150);
			end else if (ready_roll < 75) begin
				out_ready <= 1'b1;
			end else if (ready_roll < 97) begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(10, 40);
			end
		end
	end

	// Monitor.
	ring_reply_t reply_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (out_valid && out_ready) begin
			if (results_seen >= requests_issued) begin
				$error("reply transaction with no request outstanding");
				fault_count++;
			end else begin
				reply_want = ring_replies_due.pop_front();
				if (read_handle !== reply_want.handle) begin
					$error("read_handle: expected %h, got %h", reply_want.handle, read_handle);
					fault_count++;
				end
				if (fill_count !== reply_want.count) begin
					$error("fill_count: expected %0d, got %0d", reply_want.count, fill_count);
					fault_count++;
				end
				if (error_code !== reply_want.err) begin
					$error("error_code: expected %0d, got %0d", reply_want.err, error_code);
					fault_count++;
				end
			end
			results_seen <= results_seen + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[ring_queue_with_rollback] ERROR");
			$finish;
		end
	end

	initial begin
		int len;
		int mode;
		int r;
		int g;
		int planned;
		bit calm;
		logic [KIND_W-1:0] k;
		logic [HANDLE_FW-1:0] h;
		logic [SIZE_FW-1:0] sz;

		// Empty get, ignored kind, then add, roll back across the wrap and drain.
		plan_request(REQ_GET, 32'h5A5A_5A5A, 0);
		plan_request(KIND_UNUSED, 32'hFFFF_FFFF, 0);
		plan_request(REQ_ADD, 32'h0000_0000, 0);
		plan_request(REQ_ADD, 32'hFFFF_FFFF, 1);
		plan_request(REQ_ROLL, 32'hA5A5_A5A5, 0);
		plan_request(REQ_GET, 32'hFFFF_FFFF, 0);
		plan_request(REQ_GET, 32'h0000_0000, 0);
		plan_request(REQ_GET, 32'h1111_1111, 0);
		plan_request(REQ_GET, 32'h2222_2222, 0);
		// A zero size acts as a single place: full on both add and rollback.
		plan_resize(5'd0);
		plan_request(REQ_ADD, 32'h1234_5678, 0);
		plan_request(REQ_ADD, 32'h0F0F_0F0F, 0);
		plan_request(REQ_ROLL, 32'h0000_0001, 0);
		plan_request(REQ_GET, 32'h0000_0000, 2);
		plan_request(REQ_GET, 32'h0000_0000, 0);
		plan_request(REQ_ROLL, 32'hDEAD_BEEF, 0);
		plan_request(REQ_GET, 32'h0000_0000, 0);
		plan_resize(5'd2);
		plan_request(REQ_ADD, 32'h0000_0001, 0);
		plan_request(REQ_ROLL, 32'h0000_0002, 0);
		plan_request(REQ_ADD, 32'h0000_0003, 0);
		plan_request(KIND_UNUSED, 32'h8000_0000, 0);
		plan_request(REQ_GET, 32'h0000_0000, 0);
		plan_request(REQ_GET, 32'h0000_0000, 0);
		// Sizes above the store depth saturate.
		plan_resize(5'd31);

		planned = 0;
		while (planned < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 19);
				if (r == 0) begin
					sz = 5'd0;
				end else if (r == 1) begin
					sz = 5'd31;
				end else if (r < 4) begin
					sz = 5'd16;
				end else if (r == 4) begin
					sz = $urandom_range(17, 30);
				end else if (r < 8) begin
					sz = $urandom_range(6, 15);
				end else begin
					sz = $urandom_range(1, 5);
				end
				plan_resize(sz);
			end
			calm = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 2);
			len = $urandom_range(30, 110);
			for (int i = 0; i < len; i++) begin
				// Fill-heavy, drain-heavy and balanced phases push the ring to both ends.
				r = $urandom_range(0, 99);
				if (r < (mode == 0 ? 50 : mode == 1 ? 20 : 35)) begin
					k = REQ_ADD;
				end else if (r < (mode == 0 ? 75 : mode == 1 ? 32 : 50)) begin
					k = REQ_ROLL;
				end else if (r < 96) begin
					k = REQ_GET;
				end else begin
					k = KIND_UNUSED;
				end
				r = $urandom_range(0, 99);
				if (r < 4) begin
					h = '0;
				end else if (r < 8) begin
					h = '1;
				end else begin
					h = $urandom;
				end
				r = $urandom_range(0, 99);
				if (calm || r < 55) begin
					g = 0;
				end else if (r < 90) begin
					g = $urandom_range(1, 3);
				end else if (r < 98) begin
					g = $urandom_range(4, 12);
				end else begin
					g = $urandom_range(20, 60);
				end
				plan_request(k, h, g);
				planned++;
				if ($urandom_range(0, 199) == 0) begin
					plan_pause();
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				plan_pause();
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_plan.size() != 0 || in_valid || cfg_we ||
			requests_issued != results_seen) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (ring_replies_due.size() != 0) begin
			$error("%0d predicted replies never arrived", ring_replies_due.size());
			fault_count++;
		end
		if (fault_count == 0) begin
			$display("[ring_queue_with_rollback] OK");
		end else begin
			$display("[ring_queue_with_rollback] ERROR");
		end
		$finish;
	end

endmodule
